@@ hdl/scf_pkg.sv @@
package scf_pkg;

  localparam logic [7:0] START_BYTE    = 8'hFE;
  localparam logic [7:0] MAX_FRAME_LEN = 8'd15;

  localparam logic [7:0] CMD_REPLY_ONE   = 8'h01;
  localparam logic [7:0] CMD_STATUS      = 8'h02;
  localparam logic [7:0] CMD_REPLY_THREE = 8'h03;

  // Reply jobs handed from the parser to the emitter.
  localparam logic [1:0] JOB_NONE   = 2'd0;
  localparam logic [1:0] JOB_ONE    = 2'd1;
  localparam logic [1:0] JOB_THREE  = 2'd2;
  localparam logic [1:0] JOB_STATUS = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } job_t;

  function automatic logic [3:0] reply_len(input logic [1:0] code);
    logic [3:0] n;
    unique case (code)
      JOB_ONE:    n = 4'd9;
      JOB_THREE:  n = 4'd8;
      JOB_STATUS: n = 4'd1;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [1:0] code, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (code == JOB_ONE) begin
      case (idx)
        4'd0:    b = 8'hFE;
        4'd1:    b = 8'h07;
        4'd2:    b = 8'h00;
        4'd3:    b = 8'h02;
        4'd4:    b = 8'h01;
        4'd5:    b = 8'd23;
        4'd6:    b = 8'd48;
        4'd7:    b = 8'h51;
        4'd8:    b = 8'h45;
        default: b = 8'h00;
      endcase
    end else if (code == JOB_THREE) begin
      case (idx)
        4'd0:    b = 8'hFE;
        4'd1:    b = 8'h07;
        4'd2:    b = 8'h00;
        4'd3:    b = 8'h02;
        4'd4:    b = 8'h03;
        4'd5:    b = 8'h01;
        4'd6:    b = 8'h0D;
        4'd7:    b = 8'h45;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

@@ hdl/scf_parse.sv @@
module scf_parse import scf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       job_take,
  output job_t       job
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0] phase, phase_next;
  logic [3:0] data_expected, data_expected_next;
  logic [3:0] data_count, data_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] command_code, command_code_next;
  logic [3:0] count_inc;
  logic [7:0] cmd_eff;
  logic [1:0] job_new;

  assign count_inc = data_count + 4'd1;
  // on a length-4 frame the command byte is also the checksum byte
  assign cmd_eff   = (data_count == 4'd2) ? rx_byte : command_code;

  always_comb begin
    phase_next         = phase;
    data_expected_next = data_expected;
    data_count_next    = data_count;
    running_sum_next   = running_sum;
    command_code_next  = command_code;
    job_new            = JOB_NONE;
    unique case (phase)
      PH_LEN: begin
        if (rx_byte == 8'd0 || rx_byte > MAX_FRAME_LEN) begin
          phase_next = PH_HUNT;
        end else begin
          data_expected_next = (rx_byte > 8'd1) ? rx_byte[3:0] - 4'd1 : 4'd1;
          data_count_next    = 4'd0;
          running_sum_next   = rx_byte;
          phase_next         = PH_DATA;
        end
      end
      PH_DATA: begin
        command_code_next = cmd_eff;
        data_count_next   = count_inc;
        if (count_inc >= data_expected) begin
          if (rx_byte == running_sum && count_inc >= 4'd3) begin
            if (cmd_eff == CMD_REPLY_ONE) begin
              job_new = JOB_ONE;
            end else if (cmd_eff == CMD_REPLY_THREE) begin
              job_new = JOB_THREE;
            end else if (cmd_eff == CMD_STATUS) begin
              job_new = JOB_STATUS;
            end
          end
          phase_next = PH_HUNT;
        end else begin
          running_sum_next = running_sum + rx_byte;
        end
      end
      default: begin
        phase_next = (rx_byte == START_BYTE) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      data_expected <= 4'd0;
      data_count    <= 4'd0;
      running_sum   <= 8'd0;
      command_code  <= 8'd0;
      job.valid     <= 1'b0;
      job.code      <= JOB_NONE;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        data_expected <= data_expected_next;
        data_count    <= data_count_next;
        running_sum   <= running_sum_next;
        command_code  <= command_code_next;
      end
      if (accept && job_new != JOB_NONE) begin
        job.valid <= 1'b1;
        job.code  <= job_new;
      end else if (job_take) begin
        job.valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/scf_emit.sv @@
module scf_emit import scf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       job,
  output logic       job_take,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       status_request,
  output logic       last
);

  logic       active;
  logic [1:0] cur_code;
  logic [3:0] idx;
  logic       out_adv;
  logic [3:0] cur_len;

  assign out_adv  = !out_valid || !out_stall;
  assign job_take = out_adv && !active && job.valid;
  assign cur_len  = reply_len(cur_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      cur_code  <= JOB_NONE;
      idx       <= 4'd0;
    end else if (out_adv) begin
      if (active) begin
        out_valid      <= 1'b1;
        tx_byte        <= reply_byte(cur_code, idx);
        status_request <= 1'b0;
        last           <= (idx == cur_len - 4'd1);
        idx            <= idx + 4'd1;
        if (idx == cur_len - 4'd1) begin
          active <= 1'b0;
        end
      end else if (job.valid) begin
        out_valid      <= 1'b1;
        tx_byte        <= reply_byte(job.code, 4'd0);
        status_request <= (job.code == JOB_STATUS);
        last           <= (reply_len(job.code) == 4'd1);
        cur_code       <= job.code;
        idx            <= 4'd1;
        active         <= (reply_len(job.code) != 4'd1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/serial_command_frame_parser.sv @@
// Serial command frame parser.
// Input: one received byte per request on rx_byte (in_valid / in_stall).
// Frames are FE, length L (1..15), then max(L-1,1) data bytes whose last
// byte is the 8-bit sum of L and the earlier data bytes. Bad frames vanish.
// Output: reply bytes on tx_byte with last marking the final byte of a
// reply (out_valid / out_stall). Command 1 gives 9 bytes, command 3 gives
// 8 bytes, command 2 gives one request with status_request=1, tx_byte=0.
// Throughput: one input byte per cycle while in_stall is low; the parser updates its state in the
// cycle the byte is taken. A finished frame leaves a job in a one-entry job
// register; the emitter turns it into one output byte per cycle while not
// held by out_stall, the first byte passing from the job register into the output registers.
// in_stall rises only while a job waits and the emitter is still busy with
// an earlier reply or held by out_stall. With frames back to back, a 9-byte
// reply after a 5-byte frame holds off input, longer while out_stall is high.
// Output registers hold steady while out_valid and out_stall are both high.
// Reset (rst, synchronous) returns the parser to hunting for the start
// byte, drops any pending job and clears out_valid.
module serial_command_frame_parser import scf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       status_request,
  output logic       last
);

  job_t job;
  logic job_take;
  logic accept;

  assign in_stall = job.valid && !job_take;
  assign accept   = in_valid && !in_stall;

  scf_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .job_take (job_take),
    .job      (job)
  );

  scf_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .job            (job),
    .job_take       (job_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tx_byte        (tx_byte),
    .status_request (status_request),
    .last           (last)
  );

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_request |-> tx_byte == 8'h00 && last)
    else $error("status request must be a single zero byte");

  a_reply_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && !status_request)
    else $error("reply broken before its last byte");

  a_stall_needs_job: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> job.valid)
    else $error("input stalled with no pending job");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !job.valid)
    else $error("output or job pending after reset");

endmodule

@@ test/tb_serial_command_frame_parser.sv @@
module tb_serial_command_frame_parser;
  import scf_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {HUNT, GET_LEN, GET_DATA} rx_phase_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       status_request;
    logic       last;
  } reply_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] tx_byte;
  logic       status_request;
  logic       last;

  serial_command_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tx_byte(tx_byte),
    .status_request(status_request),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [7:0] reply_one_tab [9] = '{8'hFE, 8'h07, 8'h00, 8'h02, 8'h01, 8'd23, 8'd48,
                                   8'h51, 8'h45};
  logic [7:0] reply_three_tab [8] = '{8'hFE, 8'h07, 8'h00, 8'h02, 8'h03, 8'h01, 8'h0D,
                                     8'h45};

  logic [7:0] rx_pending [$];
  reply_t     expected_replies [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_off = 1'b0;
  logic in_taken = 1'b0;
  int idle_cycles = 0;
  int errors = 0;
  int frame_bytes = 0;
  int frames_sent = 0;
  int bytes_accepted = 0;
  int replies_checked = 0;
  int status_seen = 0;
  int in_stall_cycles = 0;

  // parser state as predicted from the accepted bytes
  rx_phase_t  pr_phase = HUNT;
  logic [3:0] pr_want = 4'd0;
  logic [3:0] pr_seen = 4'd0;
  logic [7:0] pr_sum = 8'd0;
  logic [7:0] pr_cmd = 8'd0;

  task automatic flag_mismatch(input string msg);
    if (errors < 40) $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic queue_reply(input logic [7:0] cmd);
    reply_t r;
    r.status_request = 1'b0;
    if (cmd == CMD_REPLY_ONE) begin
      for (int i = 0; i < $size(reply_one_tab); i++) begin
        r.tx_byte = reply_one_tab[i];
        r.last = (i == $size(reply_one_tab) - 1);
        expected_replies.push_back(r);
      end
    end else if (cmd == CMD_REPLY_THREE) begin
      for (int i = 0; i < $size(reply_three_tab); i++) begin
        r.tx_byte = reply_three_tab[i];
        r.last = (i == $size(reply_three_tab) - 1);
        expected_replies.push_back(r);
      end
    end else if (cmd == CMD_STATUS) begin
      r.tx_byte = 8'h00;
      r.status_request = 1'b1;
      r.last = 1'b1;
      expected_replies.push_back(r);
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    case (pr_phase)
      GET_LEN: begin
        if (b == 8'd0 || b > MAX_FRAME_LEN) begin
          pr_phase = HUNT;
        end else begin
          pr_want = (b > 8'd1) ? b[3:0] - 4'd1 : 4'd1;
          pr_seen = 4'd0;
          pr_sum = b;
          pr_phase = GET_DATA;
        end
      end
      GET_DATA: begin
        if (pr_seen == 4'd2) pr_cmd = b;
        pr_seen = pr_seen + 4'd1;
        if (pr_seen >= pr_want) begin
          // short frames carry no command byte
          if (b == pr_sum && pr_seen >= 4'd3) queue_reply(pr_cmd);
          pr_phase = HUNT;
        end else begin
          pr_sum = pr_sum + b;
        end
      end
      default: begin
        pr_phase = (b == START_BYTE) ? GET_LEN : HUNT;
      end
    endcase
  endtask

  // Queues start byte, length and body. Lengths out of range stop after the length.
  task automatic push_frame(input logic [7:0] len, input logic [7:0] cmd, input bit bad_sum);
    logic [7:0] body [$];
    logic [7:0] sum;
    logic [7:0] d;
    int n;
    rx_pending.push_back(START_BYTE);
    rx_pending.push_back(len);
    frame_bytes += 2;
    frames_sent++;
    if (len == 8'd0 || len > MAX_FRAME_LEN) return;
    n = (len > 8'd1) ? int'(len) - 1 : 1;
    for (int i = 0; i < n - 1; i++) begin
      if (i == 2) d = cmd;
      else d = 8'($urandom_range(255));
      body.push_back(d);
    end
    // with three data bytes the command byte doubles as the checksum
    if (n == 3) body[1] = cmd - len - body[0];
    sum = len;
    foreach (body[i]) sum = sum + body[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    foreach (body[i]) rx_pending.push_back(body[i]);
    rx_pending.push_back(sum);
    frame_bytes += n;
  endtask

  task automatic push_random_frame();
    int r;
    int c;
    logic [7:0] len;
    logic [7:0] cmd;
    r = $urandom_range(99);
    if (r < 8) begin
      rx_pending.push_back(8'($urandom_range(255)));
    end else if (r < 14) begin
      if ($urandom_range(1) == 0) len = 8'd0;
      else len = 8'($urandom_range(16, 255));
      push_frame(len, 8'h00, 1'b0);
    end else begin
      if ($urandom_range(3) == 0) len = 8'($urandom_range(1, 15));
      else len = 8'($urandom_range(3, 6));
      c = $urandom_range(9);
      if (c < 3) cmd = CMD_REPLY_ONE;
      else if (c < 5) cmd = CMD_STATUS;
      else if (c < 7) cmd = CMD_REPLY_THREE;
      else cmd = 8'($urandom_range(255));
      push_frame(len, cmd, $urandom_range(9) == 0);
    end
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int send_idle, input int stall);
    send_idle_pct = send_idle;
    stall_pct = stall;
    frame_bytes = 0;
    while (frame_bytes < 14) push_random_frame();
    wait_drained();
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        rx_byte <= rx_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: check replies, then predict from the accepted request
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_checked++;
        if (status_request) status_seen++;
        if (expected_replies.size() == 0) begin
          flag_mismatch($sformatf("unexpected reply tx_byte=%h status_request=%b last=%b",
                                  tx_byte, status_request, last));
        end else begin
          exp_r = expected_replies.pop_front();
          if (tx_byte !== exp_r.tx_byte)
            flag_mismatch($sformatf("tx_byte %h, want %h", tx_byte, exp_r.tx_byte));
          if (status_request !== exp_r.status_request)
            flag_mismatch($sformatf("status_request %b, want %b", status_request,
                                    exp_r.status_request));
          if (last !== exp_r.last)
            flag_mismatch($sformatf("last %b, want %b", last, exp_r.last));
        end
      end
      if (in_valid && !in_stall) begin
        bytes_accepted++;
        parse_rx_byte(rx_byte);
      end
      if (in_valid && in_stall) in_stall_cycles++;
      in_taken <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: bad lengths, length one, short frame, command-as-checksum, status
    push_frame(8'd0, 8'h00, 1'b0);
    push_frame(8'hFF, 8'h00, 1'b0);
    push_frame(8'd1, 8'h00, 1'b0);
    push_frame(8'd3, 8'h00, 1'b0);
    push_frame(8'd4, CMD_REPLY_ONE, 1'b0);
    push_frame(8'd4, CMD_REPLY_THREE, 1'b0);
    push_frame(8'd5, CMD_STATUS, 1'b0);
    wait_drained();

    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(35, 35);

    // long receiver hold-off while full-rate frames keep coming
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 5; i++) push_frame(8'd4, CMD_REPLY_ONE, 1'b0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    while (expected_replies.size() != 0) begin
      flag_mismatch($sformatf("reply tx_byte=%h never arrived",
                              expected_replies[0].tx_byte));
      void'(expected_replies.pop_front());
    end

    $display("Fed %0d bytes (%0d frames) under four idle/stall mixes plus a long hold-off.",
             bytes_accepted, frames_sent);
    $display("Checked %0d reply results, %0d status events; input stalled %0d cycles.",
             replies_checked, status_seen, in_stall_cycles);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
